// File: rtl/hpfd_pkg.sv
// package for the serial frame decoder: byte codes, types and queue sizing
// no dependencies
`timescale 1ns / 1ps

package hpfd_pkg;

    localparam logic [7:0] BYTE_START = 8'hFE;
    localparam logic [7:0] BYTE_SYNC  = 8'hAA;
    localparam logic [7:0] BYTE_END   = 8'h55;
    localparam logic [7:0] TYPE_B4    = 8'hB4;
    localparam logic [7:0] TYPE_SET   = 8'h02;
    localparam logic [7:0] TYPE_STAT  = 8'hB1;
    localparam logic [7:0] HEAT_OFF   = 8'h00;
    localparam logic [7:0] HEAT_ON    = 8'h64;
    localparam logic [7:0] MODE_OFF   = 8'h00;
    localparam logic [7:0] MODE_PUMP  = 8'h11;
    localparam logic [7:0] MODE_ELEC  = 8'h40;
    localparam logic [7:0] MODE_BOTH  = 8'h51;
    localparam logic [7:0] TEMP_BIAS  = 8'd30;
    localparam logic [7:0] LIMIT_RST  = 8'd100;
    localparam logic [7:0] COUNT_MAX  = 8'd255;

    localparam logic [7:0] OFS_TYPE  = 8'd2;
    localparam logic [7:0] OFS_SETP  = 8'd6;
    localparam logic [7:0] OFS_HEAT  = 8'd10;
    localparam logic [7:0] OFS_TEMP1 = 8'd16;
    localparam logic [7:0] OFS_MODE  = 8'd21;
    localparam logic [7:0] OFS_TEMP2 = 8'd23;

    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SYNC,
        ST_FRAME
    } t_stage;

    typedef enum logic {
        KIND_FRAME    = 1'b0,
        KIND_OVERFLOW = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CLS_B4      = 2'd0,
        CLS_SET     = 2'd1,
        CLS_STAT    = 2'd2,
        CLS_UNKNOWN = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        PUMP_OFF   = 2'd0,
        PUMP_ON    = 2'd1,
        PUMP_OTHER = 2'd2
    } t_pump;

    typedef enum logic [2:0] {
        HMODE_OFF   = 3'd0,
        HMODE_PUMP  = 3'd1,
        HMODE_ELEC  = 3'd2,
        HMODE_BOTH  = 3'd3,
        HMODE_OTHER = 3'd4
    } t_hmode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] count;
        logic [7:0] type_b;
        logic [7:0] setp_b;
        logic [7:0] heat_b;
        logic [7:0] temp1_b;
        logic [7:0] mode_b;
        logic [7:0] temp2_b;
    } t_rec;

endpackage

// File: rtl/heat_pump_frame_decoder.sv
// serial frame decoder: one byte per cycle while the record queue is not full; results leave through an output register
// a result is written into the record queue and then into the output register before it is valid
// throughput: one byte per cycle while the queue is not full, set by the front end state update
// a four-entry record queue lets the front end keep running while the output stalls, until the queue is full
// reset: synchronous active low, clears frame state, queue and output valid, limit to 100
// depends on hpfd_pkg, hpfd_front, hpfd_queue, hpfd_back
`timescale 1ns / 1ps

module heat_pump_frame_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [1:0]        o_msg_class,
    output logic [7:0]        o_frame_length,
    output logic [7:0]        o_setpoint,
    output logic [1:0]        o_pump_heating,
    output logic [2:0]        o_heating_mode,
    output logic signed [8:0] o_temp_one_half,
    output logic signed [8:0] o_temp_two_half,
    output logic signed [7:0] o_panel_temp
);
    import hpfd_pkg::*;

    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_rec w_front_rec;
    t_rec w_queue_rec;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    hpfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .o_push     (w_push),
        .o_rec      (w_front_rec)
    );

    hpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_rec   (w_queue_rec),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    hpfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec           (w_queue_rec),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_msg_class     (o_msg_class),
        .o_frame_length  (o_frame_length),
        .o_setpoint      (o_setpoint),
        .o_pump_heating  (o_pump_heating),
        .o_heating_mode  (o_heating_mode),
        .o_temp_one_half (o_temp_one_half),
        .o_temp_two_half (o_temp_two_half),
        .o_panel_temp    (o_panel_temp)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("record pushed into a full queue");

    a_overflow_zeroed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |->
        (o_msg_class == 2'd0 && o_setpoint == 8'd0 && o_panel_temp == 8'sd0
         && o_temp_one_half == 9'sd0 && o_temp_two_half == 9'sd0))
        else $error("overflow report carries frame fields");

    a_frame_min_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_kind) |-> (o_frame_length >= 8'd4))
        else $error("decoded frame shorter than start and end pairs");

    a_pop_needs_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("record popped from an empty queue");
`endif

endmodule

// File: rtl/hpfd_front.sv
// front end: start/end pair hunting, offset capture, overflow check
// depends on hpfd_pkg
`timescale 1ns / 1ps

module hpfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output hpfd_pkg::t_rec o_rec
);
    import hpfd_pkg::*;

    t_stage     r_stage, n_stage;
    logic       r_end, n_end;
    logic [7:0] r_count, n_count;
    logic [7:0] r_limit;
    logic [7:0] r_type, n_type;
    logic [7:0] r_setp, n_setp;
    logic [7:0] r_heat, n_heat;
    logic [7:0] r_temp1, n_temp1;
    logic [7:0] r_mode, n_mode;
    logic [7:0] r_temp2, n_temp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_HUNT;
            r_end   <= 1'b0;
            r_count <= '0;
            r_limit <= LIMIT_RST;
            r_type  <= '0;
            r_setp  <= '0;
            r_heat  <= '0;
            r_temp1 <= '0;
            r_mode  <= '0;
            r_temp2 <= '0;
        end else begin
            r_stage <= n_stage;
            r_end   <= n_end;
            r_count <= n_count;
            r_type  <= n_type;
            r_setp  <= n_setp;
            r_heat  <= n_heat;
            r_temp1 <= n_temp1;
            r_mode  <= n_mode;
            r_temp2 <= n_temp2;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_comb begin
        logic chk;
        n_stage = r_stage;
        n_end   = r_end;
        n_count = r_count;
        n_type  = r_type;
        n_setp  = r_setp;
        n_heat  = r_heat;
        n_temp1 = r_temp1;
        n_mode  = r_mode;
        n_temp2 = r_temp2;
        o_push  = 1'b0;
        o_rec   = '0;
        chk     = 1'b0;
        if (i_accept) begin
            case (r_stage)
                ST_HUNT: begin
                    if (i_rx_byte == BYTE_START) begin
                        n_end   = 1'b0;
                        n_count = 8'd1;
                        n_type  = '0;
                        n_setp  = '0;
                        n_heat  = '0;
                        n_temp1 = '0;
                        n_mode  = '0;
                        n_temp2 = '0;
                        n_stage = ST_SYNC;
                        chk     = 1'b1;
                    end
                end
                ST_SYNC: begin
                    n_end   = 1'b0;
                    n_type  = '0;
                    n_setp  = '0;
                    n_heat  = '0;
                    n_temp1 = '0;
                    n_mode  = '0;
                    n_temp2 = '0;
                    if (i_rx_byte == BYTE_SYNC) begin
                        n_count = 8'd2;
                        n_stage = ST_FRAME;
                        chk     = 1'b1;
                    end else begin
                        n_count = '0;
                        n_stage = ST_HUNT;
                    end
                end
                ST_FRAME: begin
                    if (r_count == OFS_TYPE)  n_type  = i_rx_byte;
                    if (r_count == OFS_SETP)  n_setp  = i_rx_byte;
                    if (r_count == OFS_HEAT)  n_heat  = i_rx_byte;
                    if (r_count == OFS_TEMP1) n_temp1 = i_rx_byte;
                    if (r_count == OFS_MODE)  n_mode  = i_rx_byte;
                    if (r_count == OFS_TEMP2) n_temp2 = i_rx_byte;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 8'd1;
                    end
                    if (i_rx_byte == BYTE_END && !r_end) begin
                        n_end = 1'b1;
                        chk   = 1'b1;
                    end else if (i_rx_byte == BYTE_START && r_end) begin
                        o_push        = 1'b1;
                        o_rec.kind    = KIND_FRAME;
                        o_rec.count   = n_count;
                        o_rec.type_b  = n_type;
                        o_rec.setp_b  = n_setp;
                        o_rec.heat_b  = n_heat;
                        o_rec.temp1_b = n_temp1;
                        o_rec.mode_b  = n_mode;
                        o_rec.temp2_b = n_temp2;
                        n_stage = ST_HUNT;
                        n_end   = 1'b0;
                        n_count = '0;
                        n_type  = '0;
                        n_setp  = '0;
                        n_heat  = '0;
                        n_temp1 = '0;
                        n_mode  = '0;
                        n_temp2 = '0;
                    end else begin
                        n_end = 1'b0;
                        chk   = 1'b1;
                    end
                end
                default: begin
                    n_stage = ST_HUNT;
                end
            endcase
            if (chk && (n_count > r_limit)) begin
                o_push      = 1'b1;
                o_rec       = '0;
                o_rec.kind  = KIND_OVERFLOW;
                o_rec.count = n_count;
            end
        end
    end

endmodule

// File: rtl/hpfd_queue.sv
// short record queue between the front end and the decoder
// depends on hpfd_pkg
`timescale 1ns / 1ps

module hpfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hpfd_pkg::t_rec i_rec,
    input  logic           i_pop,
    output hpfd_pkg::t_rec o_rec,
    output logic           o_empty,
    output logic           o_full
);
    import hpfd_pkg::*;

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_AW:0]   r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    assign o_rec   = r_mem[r_rptr];
    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (Q_AW + 1)'(Q_DEPTH));

endmodule

// File: rtl/hpfd_back.sv
// back end: decodes queued records into result fields, output register
// depends on hpfd_pkg
`timescale 1ns / 1ps

module hpfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpfd_pkg::t_rec    i_rec,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_kind,
    output logic [1:0]        o_msg_class,
    output logic [7:0]        o_frame_length,
    output logic [7:0]        o_setpoint,
    output logic [1:0]        o_pump_heating,
    output logic [2:0]        o_heating_mode,
    output logic signed [8:0] o_temp_one_half,
    output logic signed [8:0] o_temp_two_half,
    output logic signed [7:0] o_panel_temp
);
    import hpfd_pkg::*;

    logic              r_valid;
    t_kind             r_kind, n_kind;
    t_class            r_cls, n_cls;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_setp, n_setp;
    t_pump             r_pump, n_pump;
    t_hmode            r_mode, n_mode;
    logic signed [8:0] r_t1, n_t1;
    logic signed [8:0] r_t2, n_t2;
    logic signed [7:0] r_disp, n_disp;

    assign o_pop = !i_empty && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_cls  <= n_cls;
            r_len  <= n_len;
            r_setp <= n_setp;
            r_pump <= n_pump;
            r_mode <= n_mode;
            r_t1   <= n_t1;
            r_t2   <= n_t2;
            r_disp <= n_disp;
        end
    end

    always_comb begin
        t_class            cls;
        logic signed [8:0] t1;
        logic signed [8:0] t2;
        logic signed [8:0] h1;
        logic signed [8:0] h2;
        logic signed [8:0] sum;
        logic signed [8:0] half;
        if (i_rec.type_b == TYPE_B4)        cls = CLS_B4;
        else if (i_rec.type_b == TYPE_SET)  cls = CLS_SET;
        else if (i_rec.type_b == TYPE_STAT) cls = CLS_STAT;
        else                                cls = CLS_UNKNOWN;
        t1   = $signed({1'b0, i_rec.temp1_b}) - $signed({1'b0, TEMP_BIAS});
        t2   = $signed({1'b0, i_rec.temp2_b}) - $signed({1'b0, TEMP_BIAS});
        // halving rounds toward zero
        h1   = (t1 + (t1[8] ? 9'sd1 : 9'sd0)) >>> 1;
        h2   = (t2 + (t2[8] ? 9'sd1 : 9'sd0)) >>> 1;
        sum  = h1 + h2;
        half = (sum + (sum[8] ? 9'sd1 : 9'sd0)) >>> 1;

        n_kind = i_rec.kind;
        n_len  = i_rec.count;
        n_cls  = CLS_B4;
        n_setp = '0;
        n_pump = PUMP_OFF;
        n_mode = HMODE_OFF;
        n_t1   = '0;
        n_t2   = '0;
        n_disp = '0;
        if (i_rec.kind == KIND_FRAME) begin
            n_cls = cls;
            if (cls == CLS_SET) begin
                n_setp = i_rec.setp_b;
            end
            if (cls == CLS_STAT) begin
                if (i_rec.heat_b == HEAT_OFF)     n_pump = PUMP_OFF;
                else if (i_rec.heat_b == HEAT_ON) n_pump = PUMP_ON;
                else                              n_pump = PUMP_OTHER;
                if (i_rec.mode_b == MODE_OFF)       n_mode = HMODE_OFF;
                else if (i_rec.mode_b == MODE_PUMP) n_mode = HMODE_PUMP;
                else if (i_rec.mode_b == MODE_ELEC) n_mode = HMODE_ELEC;
                else if (i_rec.mode_b == MODE_BOTH) n_mode = HMODE_BOTH;
                else                                n_mode = HMODE_OTHER;
                n_t1   = t1;
                n_t2   = t2;
                n_disp = half[7:0];
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_result_kind   = r_kind;
    assign o_msg_class     = r_cls;
    assign o_frame_length  = r_len;
    assign o_setpoint      = r_setp;
    assign o_pump_heating  = r_pump;
    assign o_heating_mode  = r_mode;
    assign o_temp_one_half = r_t1;
    assign o_temp_two_half = r_t2;
    assign o_panel_temp    = r_disp;

endmodule

// File: test/hpfd_checker.sv
// result checker for the serial frame decoder: tracks every byte transfer,
// predicts decoded frames and overflow reports, compares each result transfer
// depends on hpfd_pkg for byte codes, stages and result codes
`timescale 1ns / 1ps

module hpfd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_result_kind,
    input  logic [1:0]        i_msg_class,
    input  logic [7:0]        i_frame_length,
    input  logic [7:0]        i_setpoint,
    input  logic [1:0]        i_pump_heating,
    input  logic [2:0]        i_heating_mode,
    input  logic signed [8:0] i_temp_one_half,
    input  logic signed [8:0] i_temp_two_half,
    input  logic signed [7:0] i_panel_temp,
    output int                fails,
    output int                pending,
    output int                n_frames,
    output int                n_overflows
);
    import hpfd_pkg::*;

    typedef struct packed {
        t_kind             kind;
        t_class            cls;
        logic [7:0]        len;
        logic [7:0]        setp;
        t_pump             pump;
        t_hmode            mode;
        logic signed [8:0] t1;
        logic signed [8:0] t2;
        logic signed [7:0] disp;
    } t_expect;

    t_expect    exp_q[$];
    t_stage     stage;
    logic       end_pend;
    logic [7:0] count;
    logic [7:0] limit;
    logic [7:0] type_b;
    logic [7:0] setp_b;
    logic [7:0] heat_b;
    logic [7:0] temp1_b;
    logic [7:0] mode_b;
    logic [7:0] temp2_b;

    initial begin
        fails       = 0;
        pending     = 0;
        n_frames    = 0;
        n_overflows = 0;
    end

    task automatic clear_capture();
        end_pend = 1'b0;
        count    = '0;
        type_b   = '0;
        setp_b   = '0;
        heat_b   = '0;
        temp1_b  = '0;
        mode_b   = '0;
        temp2_b  = '0;
    endtask

    always @(posedge i_clk) begin
        t_expect want;
        t_expect got;
        int      t1;
        int      t2;
        int      disp;
        bit      do_check;
        if (!i_rst_n) begin
            exp_q.delete();
            stage = ST_HUNT;
            limit = LIMIT_RST;
            clear_capture();
        end else begin
            // result transfer against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.kind = t_kind'(i_result_kind);
                got.cls  = t_class'(i_msg_class);
                got.len  = i_frame_length;
                got.setp = i_setpoint;
                got.pump = t_pump'(i_pump_heating);
                got.mode = t_hmode'(i_heating_mode);
                got.t1   = i_temp_one_half;
                got.t2   = i_temp_two_half;
                got.disp = i_panel_temp;
                if (exp_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: kind=%0d len=%0d",
                                 got.kind, got.len);
                end else begin
                    want = exp_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $write("exp kind=%0d cls=%0d len=%0d setp=%0d pump=%0d",
                                   want.kind, want.cls, want.len, want.setp, want.pump);
                            $display(" mode=%0d t1=%0d t2=%0d disp=%0d",
                                     want.mode, $signed(want.t1), $signed(want.t2),
                                     $signed(want.disp));
                            $write("got kind=%0d cls=%0d len=%0d setp=%0d pump=%0d",
                                   got.kind, got.cls, got.len, got.setp, got.pump);
                            $display(" mode=%0d t1=%0d t2=%0d disp=%0d",
                                     got.mode, $signed(got.t1), $signed(got.t2),
                                     $signed(got.disp));
                        end
                    end else if (want.kind == KIND_FRAME) begin
                        n_frames++;
                    end else begin
                        n_overflows++;
                    end
                end
            end

            if (i_cfg_we)
                limit = i_cfg_data;

            // byte transfer into the frame predictor
            if (i_in_valid && i_in_ready) begin
                do_check = 1'b1;
                case (stage)
                    ST_HUNT: begin
                        if (i_rx_byte != BYTE_START) begin
                            do_check = 1'b0;
                        end else begin
                            clear_capture();
                            count = 8'd1;
                            stage = ST_SYNC;
                        end
                    end
                    ST_SYNC: begin
                        if (i_rx_byte != BYTE_SYNC) begin
                            stage = ST_HUNT;
                            clear_capture();
                            do_check = 1'b0;
                        end else begin
                            count = 8'd2;
                            stage = ST_FRAME;
                        end
                    end
                    default: begin
                        case (count)
                            OFS_TYPE:  type_b  = i_rx_byte;
                            OFS_SETP:  setp_b  = i_rx_byte;
                            OFS_HEAT:  heat_b  = i_rx_byte;
                            OFS_TEMP1: temp1_b = i_rx_byte;
                            OFS_MODE:  mode_b  = i_rx_byte;
                            OFS_TEMP2: temp2_b = i_rx_byte;
                            default: ;
                        endcase
                        if (count != COUNT_MAX)
                            count = count + 8'd1;
                        if (i_rx_byte == BYTE_END && !end_pend) begin
                            end_pend = 1'b1;
                        end else if (i_rx_byte == BYTE_START && end_pend) begin
                            want      = '0;
                            want.kind = KIND_FRAME;
                            want.len  = count;
                            case (type_b)
                                TYPE_B4:   want.cls = CLS_B4;
                                TYPE_SET:  want.cls = CLS_SET;
                                TYPE_STAT: want.cls = CLS_STAT;
                                default:   want.cls = CLS_UNKNOWN;
                            endcase
                            if (want.cls == CLS_SET)
                                want.setp = setp_b;
                            if (want.cls == CLS_STAT) begin
                                case (heat_b)
                                    HEAT_OFF: want.pump = PUMP_OFF;
                                    HEAT_ON:  want.pump = PUMP_ON;
                                    default:  want.pump = PUMP_OTHER;
                                endcase
                                case (mode_b)
                                    MODE_OFF:  want.mode = HMODE_OFF;
                                    MODE_PUMP: want.mode = HMODE_PUMP;
                                    MODE_ELEC: want.mode = HMODE_ELEC;
                                    MODE_BOTH: want.mode = HMODE_BOTH;
                                    default:   want.mode = HMODE_OTHER;
                                endcase
                                // halves truncate toward zero before and after the sum
                                t1 = int'(temp1_b) - int'(TEMP_BIAS);
                                t2 = int'(temp2_b) - int'(TEMP_BIAS);
                                disp = (t1 / 2 + t2 / 2) / 2;
                                want.t1   = t1[8:0];
                                want.t2   = t2[8:0];
                                want.disp = disp[7:0];
                            end
                            exp_q.insert(exp_q.size(), want);
                            stage = ST_HUNT;
                            clear_capture();
                            do_check = 1'b0;
                        end else begin
                            end_pend = 1'b0;
                        end
                    end
                endcase
                if (do_check && count > limit) begin
                    want      = '0;
                    want.kind = KIND_OVERFLOW;
                    want.len  = count;
                    exp_q.insert(exp_q.size(), want);
                end
            end
        end
        pending = exp_q.size();
    end

endmodule

// File: test/tb_top.sv
// top of the serial frame decoder testbench: clock, reset, byte and result
// traffic with random gaps, length limit changes between phases, verdict
// depends on hpfd_pkg, heat_pump_frame_decoder and hpfd_checker
`timescale 1ns / 1ps

module tb_top;
    import hpfd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 6;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic              result_kind;
    logic [1:0]        msg_class;
    logic [7:0]        frame_length;
    logic [7:0]        setpoint;
    logic [1:0]        pump_heating;
    logic [2:0]        heating_mode;
    logic signed [8:0] temp_one_half;
    logic signed [8:0] temp_two_half;
    logic signed [7:0] panel_temp;

    int fails;
    int pending;
    int n_frames;
    int n_overflows;
    int cycles;
    int items_sent;
    bit tx_steady;
    bit hold_req;

    heat_pump_frame_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_result_kind   (result_kind),
        .o_msg_class     (msg_class),
        .o_frame_length  (frame_length),
        .o_setpoint      (setpoint),
        .o_pump_heating  (pump_heating),
        .o_heating_mode  (heating_mode),
        .o_temp_one_half (temp_one_half),
        .o_temp_two_half (temp_two_half),
        .o_panel_temp    (panel_temp)
    );

    hpfd_checker frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_result_kind   (result_kind),
        .i_msg_class     (msg_class),
        .i_frame_length  (frame_length),
        .i_setpoint      (setpoint),
        .i_pump_heating  (pump_heating),
        .i_heating_mode  (heating_mode),
        .i_temp_one_half (temp_one_half),
        .i_temp_two_half (temp_two_half),
        .i_panel_temp    (panel_temp),
        .fails           (fails),
        .pending         (pending),
        .n_frames        (n_frames),
        .n_overflows     (n_overflows)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycles = 0;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("heat_pump_frame_decoder: mismatch");
            $finish;
        end
    end

    // result side: random stalls, steady stretches and one long hold-off on request
    initial begin
        int hold_left;
        int run_left;
        int stall_left;
        int r;
        hold_left  = 0;
        run_left   = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (run_left > 0) begin
                out_ready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                run_left = (r < 80) ? $urandom_range(0, 3) : $urandom_range(20, 80);
                r = $urandom_range(0, 99);
                stall_left = (r < 55) ? 0 :
                             (r < 90) ? $urandom_range(1, 3) :
                             (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit counts);
        int gap;
        int r;
        if (tx_steady) begin
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            gap = (r < 60) ? 0 :
                  (r < 90) ? $urandom_range(1, 3) :
                  (r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 50);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
        if (counts)
            items_sent++;
    endtask

    // complete frame: start pair, captured offsets as given, random filler, end pair
    task automatic send_frame(input int len, input logic [7:0] ty, input logic [7:0] sp,
                              input logic [7:0] ht, input logic [7:0] ta,
                              input logic [7:0] md, input logic [7:0] tb);
        logic [7:0] v;
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                v = BYTE_START;
            end else if (i == 1) begin
                v = BYTE_SYNC;
            end else if (i == len - 1) begin
                v = BYTE_START;
            end else if (i == len - 2) begin
                v = BYTE_END;
            end else begin
                case (i)
                    2:       v = ty;
                    6:       v = sp;
                    10:      v = ht;
                    16:      v = ta;
                    21:      v = md;
                    23:      v = tb;
                    default: begin
                        v = 8'($urandom_range(0, 255));
                        if (v == BYTE_END)
                            v = 8'h56;
                    end
                endcase
            end
            send_byte(v, 1'b1);
        end
    endtask

    task automatic set_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [7:0] limit_plan [PHASES];
        logic [7:0] ty;
        logic [7:0] ht;
        logic [7:0] md;
        logic [7:0] ta;
        logic [7:0] tb;
        logic [7:0] v;
        int         target;
        int         len;
        int         r;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        items_sent = 0;
        tx_steady  = 1'b0;
        hold_req   = 1'b0;
        limit_plan = '{LIMIT_RST, 8'd0, COUNT_MAX, 8'd26, 8'd8, LIMIT_RST};
        limit_plan[4] = 8'($urandom_range(1, 254));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes outside a frame, broken start pairs, shortest frame, cancelled end pair
        send_byte(8'h00, 1'b0);
        send_byte(BYTE_END, 1'b0);
        send_byte(BYTE_START, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(BYTE_START, 1'b1);
        send_byte(BYTE_START, 1'b1);
        send_frame(4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(BYTE_START, 1'b1);
        send_byte(BYTE_SYNC, 1'b1);
        send_byte(BYTE_END, 1'b1);
        send_byte(BYTE_END, 1'b1);
        send_byte(BYTE_END, 1'b1);
        send_byte(BYTE_START, 1'b1);
        // settings, status at both temperature extremes, short status frame, short B4 frame
        send_frame(10, TYPE_SET, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(26, TYPE_STAT, 8'h20, HEAT_ON, 8'hFF, MODE_BOTH, 8'hFF);
        send_frame(26, TYPE_STAT, 8'h20, 8'h33, 8'h00, 8'h7E, 8'h00);
        send_frame(12, TYPE_STAT, 8'h00, HEAT_OFF, 8'h00, 8'h00, 8'h00);
        send_frame(5, TYPE_B4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0)
                set_limit(limit_plan[phase]);
            if (limit_plan[phase] == 8'd0) begin
                // every frame byte but the closing start byte overflows here, so a long hold-off fills the block
                hold_req = 1'b1;
                tx_steady = 1'b1;
                send_frame(60, TYPE_STAT, 8'h00, HEAT_ON, 8'h50, MODE_PUMP, 8'h50);
            end
            target = items_sent + 265;
            while (items_sent < target) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 85) begin
                    r = $urandom_range(0, 4);
                    ty = (r == 0) ? TYPE_B4 : (r == 1) ? TYPE_SET :
                         (r == 4) ? 8'($urandom_range(0, 255)) : TYPE_STAT;
                    r = $urandom_range(0, 2);
                    ht = (r == 0) ? HEAT_OFF : (r == 1) ? HEAT_ON :
                         8'($urandom_range(0, 255));
                    r = $urandom_range(0, 4);
                    md = (r == 0) ? MODE_OFF : (r == 1) ? MODE_PUMP :
                         (r == 2) ? MODE_ELEC : (r == 3) ? MODE_BOTH :
                         8'($urandom_range(0, 255));
                    r = $urandom_range(0, 9);
                    ta = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    r = $urandom_range(0, 9);
                    tb = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    r = $urandom_range(0, 99);
                    len = (r < 70) ? $urandom_range(24, 28) :
                          (r < 90) ? $urandom_range(4, 23) :
                          (r < 98) ? $urandom_range(29, 120) : $urandom_range(200, 300);
                    send_frame(len, ty, 8'($urandom_range(0, 255)), ht, ta, md, tb);
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            repeat ($urandom_range(1, 4))
                                send_byte(8'($urandom_range(0, 255)), 1'b0);
                        end
                        1: begin
                            v = 8'($urandom_range(0, 255));
                            if (v == BYTE_SYNC)
                                v = BYTE_START;
                            send_byte(BYTE_START, 1'b1);
                            send_byte(v, 1'b1);
                        end
                        2: begin
                            send_byte(BYTE_START, 1'b1);
                            send_byte(BYTE_SYNC, 1'b1);
                            repeat ($urandom_range(0, 6))
                                send_byte(8'($urandom_range(0, 255)), 1'b1);
                            send_byte(BYTE_END, 1'b1);
                            send_byte(BYTE_END, 1'b1);
                            send_byte(8'($urandom_range(0, 255)), 1'b1);
                            send_byte(BYTE_END, 1'b1);
                            send_byte(BYTE_START, 1'b1);
                        end
                        default: begin
                            // frame cut short, swallows whatever follows up to an end pair
                            send_byte(BYTE_START, 1'b1);
                            send_byte(BYTE_SYNC, 1'b1);
                            repeat ($urandom_range(2, 12)) begin
                                v = 8'($urandom_range(0, 255));
                                if (v == BYTE_END)
                                    v = 8'h56;
                                send_byte(v, 1'b1);
                            end
                        end
                    endcase
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("sent %0d frame bytes across %0d length limit settings", items_sent, PHASES);
        $display("checked %0d decoded frames and %0d overflow reports", n_frames, n_overflows);
        if (fails == 0 && pending == 0) begin
            $display("heat_pump_frame_decoder: match");
        end else begin
            $display("heat_pump_frame_decoder: mismatch");
        end
        $finish;
    end

endmodule
